// ===== src/cscan_disk_request_scheduler_core_assert.svh =====
// Assertion macros used by the scheduler core.
`ifndef CSCAN_DISK_REQUEST_SCHEDULER_CORE_ASSERT_SVH
`define CSCAN_DISK_REQUEST_SCHEDULER_CORE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define CSCAN_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define CSCAN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/cscan_pkg.sv =====
// Package with codes, default sizes and chain control types for the C-SCAN scheduler.
`default_nettype none
package cscan_pkg;

  // Default sizes.
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TRACK_BITS_DEF  = 16;
  localparam int TRACK_FIELD_W   = 16;
  localparam int TAG_W           = 4;

  // Operation codes carried in the input selector.
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Result kinds.
  localparam logic KIND_GRANT  = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  // Command to one sorted chain.
  typedef struct packed {
    logic ins;
    logic pop;
  } chain_cmd_t;

  // Status of one sorted chain.
  typedef struct packed {
    logic empty;
    logic full;
  } chain_stat_t;

endpackage
`default_nettype wire

// ===== src/cscan_disk_request_scheduler_core.sv =====
// C-SCAN disk head scheduler: two sorted cell chains and a capture/execute sequencer.
// Each accepted item is captured and then executed; the execute step waits while an
// earlier result beat is still held, and a result, if any, is registered as an output beat.
// The block takes no new item until the execute step of the last one is done; each
// chain inserts or pops an entry in the execute step. Reset: synchronous, active high;
// clears the state, head, phase, output valid and every cell's valid bit, so items are accepted once reset is released.
`default_nettype none
`include "cscan_disk_request_scheduler_core_assert.svh"
module cscan_disk_request_scheduler_core
  import cscan_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TRACK_BITS  = TRACK_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // track [15:0], requester [19:16], zero [23:20]
  input  wire logic        s_tuser,   // op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // granted_requester [3:0], granted_track [19:4], zero
  output logic             m_tuser    // kind
);

  localparam int TW = (TRACK_BITS < TRACK_FIELD_W) ? TRACK_BITS : TRACK_FIELD_W;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t             state;
  logic               op_q;
  logic [TW-1:0]      trk_q;
  logic [TAG_W-1:0]   tag_q;
  logic               head_busy;
  logic               head_busy_next;
  logic [TW-1:0]      head_pos;
  logic [TW-1:0]      head_pos_next;
  logic               phase;
  logic               phase_next;
  logic               out_kind;
  logic [TAG_W-1:0]   out_tag;
  logic [TW-1:0]      out_trk;

  chain_cmd_t         cmd_a;
  chain_cmd_t         cmd_b;
  chain_stat_t        stat_a;
  chain_stat_t        stat_b;
  logic [TW-1:0]      front_trk_a;
  logic [TW-1:0]      front_trk_b;
  logic [TAG_W-1:0]   front_tag_a;
  logic [TAG_W-1:0]   front_tag_b;

  logic               step_go;
  logic               res_valid;
  logic               res_kind;
  logic [TAG_W-1:0]   res_tag;
  logic [TW-1:0]      res_trk;
  logic               to_a;
  logic               act_empty;
  logic               pop_a;

  // Two sorted queues; phase says which one holds the upper tracks.
  cscan_chain #(
    .DEPTH(QUEUE_DEPTH),
    .TW   (TW)
  ) u_chain_a (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_a),
    .new_trk  (trk_q),
    .new_tag  (tag_q),
    .stat     (stat_a),
    .front_trk(front_trk_a),
    .front_tag(front_tag_a)
  );

  cscan_chain #(
    .DEPTH(QUEUE_DEPTH),
    .TW   (TW)
  ) u_chain_b (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_b),
    .new_trk  (trk_q),
    .new_tag  (tag_q),
    .stat     (stat_b),
    .front_trk(front_trk_b),
    .front_tag(front_tag_b)
  );

  assign s_tready = (state == ST_IDLE);
  // The execute step waits while an earlier result beat is still held.
  assign step_go  = (state == ST_EXEC) && (!m_tvalid || m_tready);

  // Upper requests go to queue A in phase zero, to queue B in phase one.
  assign to_a      = ((trk_q >= head_pos) == (phase == 1'b0));
  assign act_empty = phase ? stat_b.empty : stat_a.empty;
  assign pop_a     = ((phase ^ act_empty) == 1'b0);

  // Scheduling decision for the captured item.
  always_comb begin
    cmd_a          = '0;
    cmd_b          = '0;
    head_busy_next = head_busy;
    head_pos_next  = head_pos;
    phase_next     = phase;
    res_valid      = 1'b0;
    res_kind       = KIND_GRANT;
    res_tag        = tag_q;
    res_trk        = trk_q;
    if (step_go) begin
      unique case (op_q)
        OP_REQUEST: begin
          if (!head_busy) begin
            head_busy_next = 1'b1;
            head_pos_next  = trk_q;
            res_valid      = 1'b1;
          end else if (to_a ? stat_a.full : stat_b.full) begin
            res_valid = 1'b1;
            res_kind  = KIND_REJECT;
          end else if (to_a) begin
            cmd_a.ins = 1'b1;
          end else begin
            cmd_b.ins = 1'b1;
          end
        end
        OP_RELEASE: begin
          if (stat_a.empty && stat_b.empty) begin
            head_busy_next = 1'b0;
          end else begin
            phase_next = phase ^ act_empty;
            res_valid  = 1'b1;
            if (pop_a) begin
              cmd_a.pop = 1'b1;
              res_tag   = front_tag_a;
              res_trk   = front_trk_a;
            end else begin
              cmd_b.pop = 1'b1;
              res_tag   = front_tag_b;
              res_trk   = front_trk_b;
            end
            head_pos_next = res_trk;
          end
        end
        default: begin
          head_busy_next = head_busy;
        end
      endcase
    end
  end

  // Sequencer, head state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head_busy <= 1'b0;
      head_pos  <= '0;
      phase     <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      head_busy <= head_busy_next;
      head_pos  <= head_pos_next;
      phase     <= phase_next;
      // A step with a result raises the beat; a taken beat is otherwise dropped.
      if (step_go && res_valid) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (step_go) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Captured item and result payload.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_q  <= s_tuser;
      trk_q <= s_tdata[TW-1:0];
      tag_q <= s_tdata[TRACK_FIELD_W +: TAG_W];
    end
    if (step_go && res_valid) begin
      out_kind <= res_kind;
      out_tag  <= res_tag;
      out_trk  <= res_trk;
    end
  end

  assign m_tuser = out_kind;
  assign m_tdata = {4'b0000, TRACK_FIELD_W'(out_trk), out_tag};

  // An idle head leaves nobody waiting.
  `CSCAN_ASSERT_ALWAYS(a_idle_empty, head_busy || (stat_a.empty && stat_b.empty),
                       "idle head with waiters")
  // A queue is never asked to take an entry while it is full.
  `CSCAN_ASSERT_ALWAYS(a_ins_a_room, !(cmd_a.ins && stat_a.full), "insert into full queue A")
  `CSCAN_ASSERT_ALWAYS(a_ins_b_room, !(cmd_b.ins && stat_b.full), "insert into full queue B")
  // A grant always leaves the head busy.
  `CSCAN_ASSERT_NEXT(a_grant_busy, step_go && res_valid && (res_kind == KIND_GRANT),
                     head_busy, "grant without busy head")

endmodule
`default_nettype wire

// ===== src/cscan_cell.sv =====
// One cell of a sorted request chain: holds one entry and trades with its neighbours.
`default_nettype none
module cscan_cell
  import cscan_pkg::*;
#(
  parameter int TW = TRACK_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire chain_cmd_t       cmd,
  input  wire logic [TW-1:0]    new_trk,
  input  wire logic [TAG_W-1:0] new_tag,
  input  wire logic             left_valid,
  input  wire logic             left_gt,
  input  wire logic [TW-1:0]    left_trk,
  input  wire logic [TAG_W-1:0] left_tag,
  input  wire logic             right_valid,
  input  wire logic [TW-1:0]    right_trk,
  input  wire logic [TAG_W-1:0] right_tag,
  output logic                  valid,
  output logic                  gt,
  output logic [TW-1:0]         trk,
  output logic [TAG_W-1:0]      tag
);

  // The new entry goes after every entry with an equal or smaller track.
  assign gt = valid && (trk > new_trk);

  // Shift towards the back on insert, towards the front on pop.
  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      trk <= right_trk;
      tag <= right_tag;
    end else if (cmd.ins) begin
      if (left_gt) begin
        trk <= left_trk;
        tag <= left_tag;
      end else if (gt || (!valid && left_valid)) begin
        trk <= new_trk;
        tag <= new_tag;
      end
    end
  end

  // Occupancy of the cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.pop) begin
      valid <= right_valid;
    end else if (cmd.ins) begin
      if (left_gt || gt || (!valid && left_valid)) begin
        valid <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/cscan_chain.sv =====
// Sorted queue built as a row of cells, front entry at cell zero.
`default_nettype none
module cscan_chain
  import cscan_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  parameter int TW    = TRACK_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire chain_cmd_t       cmd,
  input  wire logic [TW-1:0]    new_trk,
  input  wire logic [TAG_W-1:0] new_tag,
  output chain_stat_t           stat,
  output logic [TW-1:0]         front_trk,
  output logic [TAG_W-1:0]      front_tag
);

  logic [DEPTH-1:0]   valid;
  logic [DEPTH-1:0]   gt;
  logic [TW-1:0]      trk [DEPTH];
  logic [TAG_W-1:0]   tag [DEPTH];

  // Row of cells; the ends see an always-valid left and an empty right.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             lv;
    logic             lg;
    logic [TW-1:0]    lt;
    logic [TAG_W-1:0] lx;
    logic             rv;
    logic [TW-1:0]    rt;
    logic [TAG_W-1:0] rx;

    if (i == 0) begin : g_first
      assign lv = 1'b1;
      assign lg = 1'b0;
      assign lt = new_trk;
      assign lx = new_tag;
    end else begin : g_mid
      assign lv = valid[i-1];
      assign lg = gt[i-1];
      assign lt = trk[i-1];
      assign lx = tag[i-1];
    end

    if (i == DEPTH-1) begin : g_last
      assign rv = 1'b0;
      assign rt = trk[i];
      assign rx = tag[i];
    end else begin : g_inner
      assign rv = valid[i+1];
      assign rt = trk[i+1];
      assign rx = tag[i+1];
    end

    cscan_cell #(
      .TW(TW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .new_trk    (new_trk),
      .new_tag    (new_tag),
      .left_valid (lv),
      .left_gt    (lg),
      .left_trk   (lt),
      .left_tag   (lx),
      .right_valid(rv),
      .right_trk  (rt),
      .right_tag  (rx),
      .valid      (valid[i]),
      .gt         (gt[i]),
      .trk        (trk[i]),
      .tag        (tag[i])
    );
  end

  // Valid cells always form an unbroken run from the front.
  assign stat.empty = !valid[0];
  assign stat.full  = valid[DEPTH-1];
  assign front_trk  = trk[0];
  assign front_tag  = tag[0];

endmodule
`default_nettype wire
